>>> src/mcc_pkg.sv
// ----------------------------------------------------------------------------
// mcc_pkg: shared types and constants of the minute calendar clock
// Field widths, request codes, controller states, the month table and the
// calendar carry helpers used by the calendar core, the divider and the top level.
// ----------------------------------------------------------------------------
package mcc_pkg;

  // Field widths
  localparam int STAMP_W = 32;
  localparam int PER_W   = 20;
  localparam int SUB_W   = 8;
  localparam int MIN_W   = 6;
  localparam int HOUR_W  = 5;
  localparam int DAY_W   = 5;
  localparam int MON_W   = 4;
  localparam int WKD_W   = 3;
  localparam int REQ_W   = 3;
  localparam int MU_W    = 11;

  // Divider: dividend is elapsed * 60, one bit shifted in per cycle
  localparam int DVD_W = STAMP_W + 6;
  localparam int CNT_W = $clog2(DVD_W);

  // Reset values
  localparam logic [PER_W-1:0]  PERIOD_RST = PER_W'(1000);
  localparam logic [HOUR_W-1:0] HOUR_RST   = HOUR_W'(12);
  localparam logic [WKD_W-1:0]  WKD_RST    = WKD_W'(4);

  // Calendar limits
  localparam logic [MON_W-1:0] MONTHS   = MON_W'(12);
  localparam logic [WKD_W-1:0] WEEKDAYS = WKD_W'(7);
  localparam int               MIN_PER_DAY = 24 * 60;

  // Month lengths, February at 29, indexed by month minus one
  localparam logic [DAY_W-1:0] MONTH_LEN [12] = '{
    5'd31, 5'd29, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  // Request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_TICK     = 3'd0,
    REQ_DAY_FWD  = 3'd1,
    REQ_DAY_BACK = 3'd2,
    REQ_STORE    = 3'd3,
    REQ_RESTORE  = 3'd4,
    REQ_SET      = 3'd5
  } req_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_APPLY,
    ST_REPORT
  } state_t;

  // Divider request and response
  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [PER_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [SUB_W-1:0] quot;
  } div_rsp_t;

  // Calendar update command
  typedef struct packed {
    logic               apply;
    logic [REQ_W-1:0]   req;
    logic               adv;
    logic [SUB_W-1:0]   sub;
    logic [STAMP_W-1:0] now;
    logic [HOUR_W-1:0]  th;
    logic [MIN_W-1:0]   tm;
    logic [WKD_W-1:0]   wd;
    logic [PER_W-1:0]   period;
  } cal_cmd_t;

  // Calendar state as seen by the top level
  typedef struct packed {
    logic [MIN_W-1:0]   minute;
    logic [HOUR_W-1:0]  hour;
    logic [DAY_W-1:0]   day;
    logic [MON_W-1:0]   month;
    logic [WKD_W-1:0]   weekday;
    logic [SUB_W-1:0]   sub;
    logic [STAMP_W-1:0] stamp;
    logic               saved;
  } cal_state_t;

  // Day and month pair for carry helpers
  typedef struct packed {
    logic [DAY_W-1:0] day;
    logic [MON_W-1:0] month;
  } dm_t;

  // Days in a month; an invalid month counts as 31
  function automatic logic [DAY_W-1:0] days_of(input logic [MON_W-1:0] m);
    logic [MON_W-1:0] idx;
    idx = m - MON_W'(1);
    if (m >= MON_W'(1) && m <= MONTHS) begin
      return MONTH_LEN[idx];
    end
    return DAY_W'(31);
  endfunction

  // One day forward with month rollover
  function automatic dm_t day_carry(input dm_t cur);
    dm_t res;
    res.day   = cur.day + DAY_W'(1);
    res.month = cur.month;
    if (res.day > days_of(cur.month) || res.day == '0) begin
      res.day   = DAY_W'(1);
      res.month = (cur.month >= MONTHS) ? MON_W'(1) : cur.month + MON_W'(1);
    end
    return res;
  endfunction

  // Weekday step, 7 wraps to 1
  function automatic logic [WKD_W-1:0] weekday_up(input logic [WKD_W-1:0] w);
    return (w >= WEEKDAYS) ? WKD_W'(1) : w + WKD_W'(1);
  endfunction

endpackage

>>> src/minute_calendar_clock_unit.sv
// ----------------------------------------------------------------------------
// minute_calendar_clock_unit: millisecond-driven calendar clock
// Accepts ticks and commands, keeps minute, hour, day, month and weekday,
// and reports the time, minutes until a target and an hour-window flag.
//
//   channel  dir  handshake             payload
//   in_      in   in_tvalid/in_tready   in_tdata, in_tuser (request kind)
//   out_     out  out_tvalid/out_tready out_tdata
//   cfg_     in   cfg_valid/cfg_ready   cfg_data (ms_per_minute)
//
// A tick raises out_tvalid after these steps: loading the bit-serial divider,
// 38 divider steps (one of 38 dividend bits each), the done strobe, the
// calendar update and the report load. Other commands raise out_tvalid after
// the calendar update and the report load. in_tready returns in the cycle after
// the report load.
// One item is in work at a time; the next is taken once the result is in the
// output register, which holds it while out_tready is low.
// Reset is synchronous, active low, and loads the calendar reset values.
// cfg_ready is always high; the register is to be written only while idle.
// ----------------------------------------------------------------------------
module minute_calendar_clock_unit import mcc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata from bit 0: now_ms[31:0], target_hour[4:0], target_minute[5:0],
  //   set_weekday[2:0], range_from[4:0], range_to[4:0]
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,
  // in_tuser from bit 0: req_type[2:0]
  input  logic [2:0]  in_tuser,
  // out_tdata from bit 0: cur_minute[5:0], cur_hour[4:0], cur_day[4:0],
  //   cur_month[3:0], cur_weekday[2:0], sub_minute[7:0], minutes_until[10:0],
  //   in_window, snapshot_valid, zero pad[3:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,
  // configuration write: ms_per_minute
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [19:0] cfg_data
);

  state_t state_r, state_nxt;

  logic [PER_W-1:0]   ms_r;
  logic [PER_W-1:0]   period;
  logic [REQ_W-1:0]   req_r;
  logic [STAMP_W-1:0] now_r;
  logic [HOUR_W-1:0]  th_r;
  logic [MIN_W-1:0]   tm_r;
  logic [WKD_W-1:0]   wd_r;
  logic [HOUR_W-1:0]  rf_r;
  logic [HOUR_W-1:0]  rt_r;
  logic [STAMP_W-1:0] elapsed_r;
  logic               adv_r;
  logic               out_valid_r;
  logic [47:0]        out_data_r, out_data_nxt;

  logic               in_acc;
  logic               div_start;
  logic               cal_apply;
  logic               out_load;

  div_req_t           dreq;
  div_rsp_t           drsp;
  cal_cmd_t           ccmd;
  cal_state_t         cst;

  logic [11:0]        nowm;
  logic [11:0]        then_v;
  logic [11:0]        then_w;
  logic [11:0]        mu_full;
  logic               win;

  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign period    = (ms_r == '0) ? PER_W'(1) : ms_r;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ms_r <= PERIOD_RST;
    end else if (cfg_valid && cfg_ready) begin
      ms_r <= cfg_data;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = (req_t'(in_tuser) == REQ_TICK) ? ST_PREP : ST_APPLY;
        end
      end
      ST_PREP:   state_nxt = ST_DIV;
      ST_DIV: begin
        if (drsp.done) begin
          state_nxt = ST_APPLY;
        end
      end
      ST_APPLY:  state_nxt = ST_REPORT;
      ST_REPORT: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Controller outputs
  always_comb begin
    in_tready = (state_r == ST_IDLE);
    div_start = (state_r == ST_PREP);
    cal_apply = (state_r == ST_APPLY);
    out_load  = (state_r == ST_REPORT) && (!out_valid_r || out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Input capture and elapsed time against the minute stamp
  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_r     <= in_tuser;
      now_r     <= in_tdata[31:0];
      th_r      <= in_tdata[36:32];
      tm_r      <= in_tdata[42:37];
      wd_r      <= in_tdata[45:43];
      rf_r      <= in_tdata[50:46];
      rt_r      <= in_tdata[55:51];
      elapsed_r <= in_tdata[31:0] - cst.stamp;
    end
    if (div_start) begin
      adv_r <= (elapsed_r > {{(STAMP_W-PER_W){1'b0}}, period});
    end
  end

  // Divider: elapsed * 60 = elapsed * 64 - elapsed * 4
  assign dreq.start    = div_start;
  assign dreq.dividend = {elapsed_r, 6'b0} - {4'b0, elapsed_r, 2'b0};
  assign dreq.divisor  = period;

  mcc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .rsp   (drsp)
  );

  // Calendar core
  assign ccmd.apply  = cal_apply;
  assign ccmd.req    = req_r;
  assign ccmd.adv    = adv_r;
  assign ccmd.sub    = drsp.quot;
  assign ccmd.now    = now_r;
  assign ccmd.th     = th_r;
  assign ccmd.tm     = tm_r;
  assign ccmd.wd     = wd_r;
  assign ccmd.period = period;

  mcc_cal u_cal (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (ccmd),
    .st    (cst)
  );

  // Report: minutes until target and hour window
  always_comb begin
    nowm   = {1'b0, cst.hour, 6'b0} - {5'b0, cst.hour, 2'b0} + {6'b0, cst.minute};
    then_v = {1'b0, th_r, 6'b0} - {5'b0, th_r, 2'b0} + {6'b0, tm_r};
    then_w = (then_v < nowm) ? then_v + 12'(MIN_PER_DAY) : then_v;
    mu_full = then_w - nowm;
    if (rf_r > rt_r) begin
      win = (cst.hour >= rf_r) || (cst.hour < rt_r);
    end else begin
      win = (cst.hour >= rf_r) && (cst.hour < rt_r);
    end
    out_data_nxt = {4'b0, cst.saved, win, mu_full[MU_W-1:0], cst.sub,
                    cst.weekday, cst.month, cst.day, cst.hour, cst.minute};
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Divider finishes only while the controller waits for it
  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    drsp.done |-> (state_r == ST_DIV))
    else $error("divider done outside divide state");

  // A finished item waits in report while the output slot is occupied
  a_report_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_REPORT && out_valid_r && !out_tready) |=>
      (state_r == ST_REPORT && out_valid_r && $stable(out_data_r)))
    else $error("pending result overwritten");

endmodule

>>> src/mcc_div.sv
// ----------------------------------------------------------------------------
// mcc_div: bit-serial restoring divider with saturated 8-bit quotient
// Shifts one dividend bit per cycle into a narrow remainder; quotient bits
// that leave the 8-bit window set a sticky overflow that saturates at 255.
// ----------------------------------------------------------------------------
module mcc_div import mcc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DVD_W-1:0] dvd_r, dvd_nxt;
  logic [PER_W-1:0] dsr_r, dsr_nxt;
  logic [PER_W-1:0] rem_r, rem_nxt;
  logic [SUB_W-1:0] quo_r, quo_nxt;
  logic             ovf_r, ovf_nxt;

  logic [PER_W:0]   trial;
  logic [PER_W+1:0] diff;
  logic             ge;
  logic             last;

  // Trial subtract of one step
  assign trial = {rem_r, dvd_r[DVD_W-1]};
  assign diff  = {1'b0, trial} - {2'b0, dsr_r};
  assign ge    = ~diff[PER_W+1];
  assign last  = (cnt_r == CNT_W'(DVD_W - 1));

  // Step logic
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    dsr_nxt  = dsr_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    ovf_nxt  = ovf_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      dvd_nxt  = req.dividend;
      dsr_nxt  = req.divisor;
      rem_nxt  = '0;
      quo_nxt  = '0;
      ovf_nxt  = 1'b0;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[DVD_W-2:0], 1'b0};
      rem_nxt = ge ? diff[PER_W-1:0] : trial[PER_W-1:0];
      quo_nxt = {quo_r[SUB_W-2:0], ge};
      ovf_nxt = ovf_r | quo_r[SUB_W-1];
      cnt_nxt = cnt_r + CNT_W'(1);
      if (last) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    dsr_r <= dsr_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    ovf_r <= ovf_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = ovf_r ? {SUB_W{1'b1}} : quo_r;

  // A new division never starts on top of a running one
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy_r)
    else $error("divider started while busy");

  // Remainder stays below the divisor throughout
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (rem_r < dsr_r))
    else $error("divider remainder out of range");

endmodule

>>> src/mcc_cal.sv
// ----------------------------------------------------------------------------
// mcc_cal: calendar state and command update
// Holds the time, date, weekday, sub-minute count, minute stamp and the
// snapshot; applies one tick or command when the controller says so.
// ----------------------------------------------------------------------------
module mcc_cal import mcc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cal_cmd_t   cmd,
  output cal_state_t st
);

  logic [MIN_W-1:0]   min_r, min_nxt;
  logic [HOUR_W-1:0]  hour_r, hour_nxt;
  logic [DAY_W-1:0]   day_r, day_nxt;
  logic [MON_W-1:0]   mon_r, mon_nxt;
  logic [WKD_W-1:0]   wkd_r, wkd_nxt;
  logic [SUB_W-1:0]   sub_r, sub_nxt;
  logic [STAMP_W-1:0] stamp_r, stamp_nxt;
  logic [MIN_W-1:0]   sv_min_r, sv_min_nxt;
  logic [HOUR_W-1:0]  sv_hour_r, sv_hour_nxt;
  logic [DAY_W-1:0]   sv_day_r, sv_day_nxt;
  logic [MON_W-1:0]   sv_mon_r, sv_mon_nxt;
  logic [SUB_W-1:0]   sv_sub_r, sv_sub_nxt;
  logic               sv_flag_r, sv_flag_nxt;

  // Next-state of the calendar
  always_comb begin
    logic [MIN_W:0]    min7;
    logic [HOUR_W:0]   hour6;
    dm_t               dm;
    min_nxt     = min_r;
    hour_nxt    = hour_r;
    day_nxt     = day_r;
    mon_nxt     = mon_r;
    wkd_nxt     = wkd_r;
    sub_nxt     = sub_r;
    stamp_nxt   = stamp_r;
    sv_min_nxt  = sv_min_r;
    sv_hour_nxt = sv_hour_r;
    sv_day_nxt  = sv_day_r;
    sv_mon_nxt  = sv_mon_r;
    sv_sub_nxt  = sv_sub_r;
    sv_flag_nxt = sv_flag_r;
    dm.day      = day_r;
    dm.month    = mon_r;
    min7        = {1'b0, min_r} + (MIN_W+1)'(1);
    hour6       = {1'b0, hour_r} + (HOUR_W+1)'(1);
    if (cmd.apply) begin
      unique case (req_t'(cmd.req))
        REQ_TICK: begin
          sub_nxt = cmd.sub;
          if (cmd.adv) begin
            stamp_nxt = stamp_r + {{(STAMP_W-PER_W){1'b0}}, cmd.period};
            if (min7 > (MIN_W+1)'(59)) begin
              min_nxt = '0;
              if (hour6 > (HOUR_W+1)'(23)) begin
                hour_nxt = '0;
                wkd_nxt  = weekday_up(wkd_r);
                dm       = day_carry(dm);
                day_nxt  = dm.day;
                mon_nxt  = dm.month;
              end else begin
                hour_nxt = hour6[HOUR_W-1:0];
              end
            end else begin
              min_nxt = min7[MIN_W-1:0];
            end
          end
        end
        REQ_DAY_FWD: begin
          dm      = day_carry(dm);
          day_nxt = dm.day;
          mon_nxt = dm.month;
          wkd_nxt = weekday_up(wkd_r);
        end
        REQ_DAY_BACK: begin
          if (day_r <= DAY_W'(1)) begin
            mon_nxt = (mon_r <= MON_W'(1) || mon_r > MONTHS) ? MONTHS
                                                              : mon_r - MON_W'(1);
            day_nxt = days_of(mon_nxt);
          end else begin
            day_nxt = day_r - DAY_W'(1);
          end
          wkd_nxt = (wkd_r <= WKD_W'(1)) ? WEEKDAYS : wkd_r - WKD_W'(1);
        end
        REQ_STORE: begin
          sv_min_nxt  = min_r;
          sv_hour_nxt = hour_r;
          sv_day_nxt  = day_r;
          sv_mon_nxt  = mon_r;
          sv_sub_nxt  = sub_r;
          sv_flag_nxt = 1'b1;
        end
        REQ_RESTORE: begin
          min_nxt  = sv_min_r;
          hour_nxt = sv_hour_r;
          day_nxt  = sv_day_r;
          mon_nxt  = sv_mon_r;
          sub_nxt  = sv_sub_r;
        end
        REQ_SET: begin
          stamp_nxt = cmd.now;
          sub_nxt   = '0;
          min7      = {1'b0, cmd.tm};
          hour6     = {1'b0, cmd.th};
          if (cmd.wd != '0) begin
            wkd_nxt = cmd.wd;
            dm      = day_carry(dm);
          end
          // out-of-range minute carries into the hour
          if (min7 >= (MIN_W+1)'(60)) begin
            min7  = min7 - (MIN_W+1)'(60);
            hour6 = hour6 + (HOUR_W+1)'(1);
          end
          // out-of-range hour carries into the day, weekday untouched
          if (hour6 >= (HOUR_W+1)'(24)) begin
            hour6 = hour6 - (HOUR_W+1)'(24);
            dm    = day_carry(dm);
          end
          min_nxt  = min7[MIN_W-1:0];
          hour_nxt = hour6[HOUR_W-1:0];
          day_nxt  = dm.day;
          mon_nxt  = dm.month;
        end
        default: begin
          // unused request codes only report
        end
      endcase
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r     <= '0;
      hour_r    <= HOUR_RST;
      day_r     <= DAY_W'(1);
      mon_r     <= MON_W'(1);
      wkd_r     <= WKD_RST;
      sub_r     <= '0;
      stamp_r   <= '0;
      sv_min_r  <= '0;
      sv_hour_r <= '0;
      sv_day_r  <= DAY_W'(1);
      sv_mon_r  <= MON_W'(1);
      sv_sub_r  <= '0;
      sv_flag_r <= 1'b0;
    end else begin
      min_r     <= min_nxt;
      hour_r    <= hour_nxt;
      day_r     <= day_nxt;
      mon_r     <= mon_nxt;
      wkd_r     <= wkd_nxt;
      sub_r     <= sub_nxt;
      stamp_r   <= stamp_nxt;
      sv_min_r  <= sv_min_nxt;
      sv_hour_r <= sv_hour_nxt;
      sv_day_r  <= sv_day_nxt;
      sv_mon_r  <= sv_mon_nxt;
      sv_sub_r  <= sv_sub_nxt;
      sv_flag_r <= sv_flag_nxt;
    end
  end

  assign st.minute  = min_r;
  assign st.hour    = hour_r;
  assign st.day     = day_r;
  assign st.month   = mon_r;
  assign st.weekday = wkd_r;
  assign st.sub     = sub_r;
  assign st.stamp   = stamp_r;
  assign st.saved   = sv_flag_r;

  // Day always fits the current month
  a_day_fits: assert property (@(posedge clk) disable iff (!rst_n)
    (day_r != '0) && (day_r <= days_of(mon_r)))
    else $error("day outside current month");

  // Time of day and month stay in range after every update
  a_time_legal: assert property (@(posedge clk) disable iff (!rst_n)
    (min_r < MIN_W'(60)) && (hour_r < HOUR_W'(24)) &&
    (mon_r != '0) && (mon_r <= MONTHS) && (wkd_r != '0))
    else $error("calendar field out of range");

endmodule
